// ===== sv/pse_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the postfix stack evaluator.
package pse_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 4;
    localparam int STAT_W = 3;

    // Token command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MOD  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_XOR  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_OR   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_NOT  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_AND  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SHL  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_SHR  = 4'd11;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MISSING  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DIVZERO  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

    typedef struct packed {
        logic             start;
        logic [CMD_W-1:0] op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

endpackage

// ===== sv/postfix_stack_evaluator_core.sv =====
`timescale 1ns / 1ps
// Postfix expression evaluator on a RAM operand stack with a shared ALU.
//
// Each slave word is one token: s_tuser carries the command, s_tdata the
// number for a push, s_tlast ends the expression. The block takes one token
// at a time and drops s_tready until the token is done: a push, a not or an
// unused code passes the execute and finish states, add/sub/mul/logic/shift
// tokens also read the left operand from RAM and run an ALU operation, and
// div/mod wait on the 32-step bit-serial divider of the ALU. The top of stack
// lives in a register, entries below it in a STACK_DEPTH-deep RAM, so no
// clearing pass is needed after reset. On the last token one master word is
// produced: m_tdata is the top of stack (zero on error) and m_tuser the
// status. The master word sits in its own register, so new tokens are taken
// while it waits; only a second last token stalls until the first is taken.
// After any error the rest of the expression is skipped until its last
// token, which reports the first error seen.
module postfix_stack_evaluator_core
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] operand_value
    input  logic [CMD_W-1:0]  s_tuser,   // [3:0] command
    input  logic              s_tlast,   // last_token
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] result_value
    output logic [STAT_W-1:0] m_tuser    // [2:0] status
);

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STAT_W-1:0] err_reg, err_next;
    logic [DATA_W-1:0] tos_reg, tos_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [DATA_W-1:0] val_reg;
    logic              last_reg;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [STAT_W-1:0] m_stat_reg, m_stat_next;

    // stack RAM port
    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data, rd_data;

    // shared ALU
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [DATA_W-1:0] alu_res;

    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic              accept;
    logic              is_binary;

    assign accept   = s_tvalid && s_tready;
    // nothing is taken while reset is held
    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_m2   = count_reg - CNT_W'(2);

    always_comb begin
        case (cmd_reg)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_XOR,
            CMD_OR, CMD_AND, CMD_SHL, CMD_SHR: is_binary = 1'b1;
            default:                           is_binary = 1'b0;
        endcase
    end

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // lhs comes straight from the RAM read register, rhs is the cached top
    pse_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .lhs     (rd_data),
        .rhs     (tos_reg),
        .rsp     (alu_rsp),
        .result  (alu_res)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        tos_next     = tos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_stat_next  = m_stat_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[IDX_W-1:0];
        wr_data      = val_reg;
        rd_en        = 1'b0;
        rd_addr      = cnt_m2[IDX_W-1:0];
        alu_req      = '{start: 1'b0, op: cmd_reg};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FINISH;
                if (err_reg == STAT_OK) begin
                    if (cmd_reg == CMD_PUSH) begin
                        if (count_reg == CNT_W'(STACK_DEPTH)) begin
                            err_next = STAT_OVERFLOW;
                        end else begin
                            wr_en      = 1'b1;
                            tos_next   = val_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (cmd_reg == CMD_NOT) begin
                        if (count_reg == '0) begin
                            err_next = STAT_MISSING;
                        end else begin
                            wr_en    = 1'b1;
                            wr_addr  = cnt_m1[IDX_W-1:0];
                            wr_data  = ~tos_reg;
                            tos_next = ~tos_reg;
                        end
                    end else if (is_binary) begin
                        if (count_reg < CNT_W'(2)) begin
                            err_next = STAT_MISSING;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                // left operand now in rd_data
                if (((cmd_reg == CMD_DIV) || (cmd_reg == CMD_MOD)) && (tos_reg == '0)) begin
                    err_next   = STAT_DIVZERO;
                    state_next = S_FINISH;
                end else begin
                    alu_req.start = 1'b1;
                    state_next    = S_WAIT;
                end
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    wr_en      = 1'b1;
                    wr_addr    = cnt_m2[IDX_W-1:0];
                    wr_data    = alu_res;
                    tos_next   = alu_res;
                    count_next = cnt_m1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (err_reg != STAT_OK) begin
                        m_stat_next = err_reg;
                        m_data_next = '0;
                    end else if (count_reg == '0) begin
                        m_stat_next = STAT_EMPTY;
                        m_data_next = '0;
                    end else begin
                        m_stat_next = STAT_OK;
                        m_data_next = tos_reg;
                    end
                    count_next = '0;
                    err_next   = STAT_OK;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            err_reg     <= STAT_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tos_reg    <= tos_next;
        m_data_reg <= m_data_next;
        m_stat_reg <= m_stat_next;
        if (accept) begin
            cmd_reg  <= s_tuser;
            val_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_stat_reg;

endmodule

// ===== sv/pse_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/pse_alu.sv =====
`timescale 1ns / 1ps
// Shared arithmetic unit: registered simple ops plus a bit-serial restoring divider.
module pse_alu
    import pse_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] lhs,
    input  logic [DATA_W-1:0] rhs,
    output alu_rsp_t          rsp,
    output logic [DATA_W-1:0] result
);

    logic                busy_reg;
    logic                done_reg;
    logic                mod_sel_reg;
    logic [4:0]          cnt_reg;
    logic [DATA_W-1:0]   quo_reg, quo_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   dvsr_reg;
    logic [DATA_W-1:0]   res_reg;
    logic [DATA_W:0]     trial;
    logic [DATA_W-1:0]   simple_res;
    logic                is_div;

    assign is_div = (req.op == CMD_DIV) || (req.op == CMD_MOD);

    // one quotient bit per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dvsr_reg};
        if (!trial[DATA_W]) begin
            rem_next = trial[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b1};
        end else begin
            rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
            quo_next = {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    // mul keeps only the low word, so a 32x32 multiplier is enough
    always_comb begin
        case (req.op)
            CMD_ADD: simple_res = lhs + rhs;
            CMD_SUB: simple_res = lhs - rhs;
            CMD_MUL: simple_res = lhs * rhs;
            CMD_XOR: simple_res = lhs ^ rhs;
            CMD_OR:  simple_res = lhs | rhs;
            CMD_AND: simple_res = lhs & rhs;
            CMD_SHL: simple_res = (rhs >= 32'd32) ? '0 : (lhs << rhs[4:0]);
            CMD_SHR: simple_res = (rhs >= 32'd32) ? '0 : (lhs >> rhs[4:0]);
            default: simple_res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if (is_div) begin
                    busy_reg    <= 1'b1;
                    cnt_reg     <= 5'd31;
                    quo_reg     <= lhs;
                    rem_reg     <= '0;
                    dvsr_reg    <= rhs;
                    mod_sel_reg <= (req.op == CMD_MOD);
                end else begin
                    res_reg  <= simple_res;
                    done_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= mod_sel_reg ? rem_next : quo_next;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = res_reg;

endmodule

// ===== sv/pse_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the postfix stack evaluator, bound to the core.
module pse_checker
    import pse_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0] m_tuser
);

    // a held master word must not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("master word changed while stalled");

    // error words carry zero data
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("nonzero data on error status");

    a_stat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_OK) || (m_tuser == STAT_MISSING) ||
                     (m_tuser == STAT_DIVZERO) || (m_tuser == STAT_OVERFLOW) ||
                     (m_tuser == STAT_EMPTY))
        else $error("status code out of range");

    // an accepted token holds off the next one while it is in flight
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("token accepted while previous token in flight");

endmodule

bind postfix_stack_evaluator_core pse_checker u_pse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the postfix stack evaluator core.
module tb_top;
    import pse_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int RANDOM_WORDS = 750;
    localparam int LONG_HOLD    = 400;     // receiver hold-off, in cycles
    localparam int TAIL_CYCLES  = 64;      // idle tail before the end of run, in cycles
    localparam int CYCLE_LIMIT  = 500000;

    // One token word as queued for the driver; pause_first holds it back
    // until every expected result has drained.
    typedef struct packed {
        logic              pause_first;
        logic              last;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
    } token_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [STAT_W-1:0] status;
    } rpn_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;    // [31:0] operand_value
    logic [CMD_W-1:0]  s_tuser  = '0;    // [3:0] command
    logic              s_tlast  = 1'b0;  // last_token
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;          // [31:0] result_value
    logic [STAT_W-1:0] m_tuser;          // [2:0] status

    postfix_stack_evaluator_core #(
        .STACK_DEPTH (DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial forever #6 aclk = ~aclk;

    token_t      token_queue[$];
    rpn_result_t pending_results[$];

    // Predictor state: operand stack, fill level, first error of the expression
    logic [DATA_W-1:0] eval_stack [DEPTH];
    int                stack_fill  = 0;
    logic [STAT_W-1:0] first_error = STAT_OK;

    int  fail_count   = 0;
    int  results_seen = 0;
    int  sent_count   = 0;
    int  send_gap     = 0;
    int  hold_left    = 0;
    int  recv_cycles  = 0;
    int  cycle_count  = 0;
    bit  word_taken   = 1'b0;
    bit  long_hold_done = 1'b0;
    bit  mark_pause   = 1'b0;

    // ---------------------------------------------------------------
    // Predictor: apply one accepted token, queue a result on last
    // ---------------------------------------------------------------
    function automatic void rpn_eval_token(input logic [CMD_W-1:0] cmd,
                                           input logic [DATA_W-1:0] value,
                                           input logic last);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] acc;
        rpn_result_t       res;
        if (first_error == STAT_OK) begin
            case (cmd)
                CMD_PUSH: begin
                    if (stack_fill >= DEPTH) begin
                        first_error = STAT_OVERFLOW;
                    end else begin
                        eval_stack[stack_fill] = value;
                        stack_fill++;
                    end
                end
                CMD_NOT: begin
                    if (stack_fill == 0)
                        first_error = STAT_MISSING;
                    else
                        eval_stack[stack_fill-1] = ~eval_stack[stack_fill-1];
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_XOR,
                CMD_OR, CMD_AND, CMD_SHL, CMD_SHR: begin
                    if (stack_fill < 2) begin
                        first_error = STAT_MISSING;
                    end else begin
                        rhs = eval_stack[stack_fill-1];
                        lhs = eval_stack[stack_fill-2];
                        if ((cmd == CMD_DIV || cmd == CMD_MOD) && rhs == '0) begin
                            first_error = STAT_DIVZERO;
                        end else begin
                            case (cmd)
                                CMD_ADD: acc = lhs + rhs;
                                CMD_SUB: acc = lhs - rhs;
                                CMD_MUL: acc = lhs * rhs;   // low 32 bits
                                CMD_DIV: acc = lhs / rhs;
                                CMD_MOD: acc = lhs % rhs;
                                CMD_XOR: acc = lhs ^ rhs;
                                CMD_OR:  acc = lhs | rhs;
                                CMD_AND: acc = lhs & rhs;
                                CMD_SHL: acc = (rhs >= DATA_W) ? '0 : lhs << rhs[4:0];
                                default: acc = (rhs >= DATA_W) ? '0 : lhs >> rhs[4:0];
                            endcase
                            eval_stack[stack_fill-2] = acc;
                            stack_fill--;
                        end
                    end
                end
                default: ;  // unused codes: no effect
            endcase
        end
        if (last) begin
            res.value = '0;
            if (first_error != STAT_OK) begin
                res.status = first_error;
            end else if (stack_fill == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                res.status = STAT_OK;
                res.value  = eval_stack[stack_fill-1];
            end
            pending_results = {pending_results, res};
            stack_fill  = 0;
            first_error = STAT_OK;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic void add_token(input logic [CMD_W-1:0] cmd,
                                      input logic [DATA_W-1:0] value,
                                      input logic last);
        token_t t;
        t.pause_first = mark_pause;
        t.last        = last;
        t.cmd         = cmd;
        t.value       = value;
        mark_pause    = 1'b0;
        token_queue   = {token_queue, t};
    endfunction

    // Biased toward zero, one, all ones and shift-sized amounts
    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 1;
            2:       return '1;
            3, 4:    return DATA_W'($urandom_range(40));
            default: return DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_binary();
        case ($urandom_range(9))
            0:       return CMD_ADD;
            1:       return CMD_SUB;
            2:       return CMD_MUL;
            3:       return CMD_DIV;
            4:       return CMD_MOD;
            5:       return CMD_XOR;
            6:       return CMD_OR;
            7:       return CMD_AND;
            8:       return CMD_SHL;
            default: return CMD_SHR;
        endcase
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers queued token words, changes inputs on falling edge
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        token_t tok;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !word_taken) begin
            // word still offered: hold it
        end else if (send_gap > 0) begin
            send_gap--;
            s_tvalid <= 1'b0;
        end else if (token_queue.size() != 0 &&
                     !(token_queue[0].pause_first && pending_results.size() != 0)) begin
            tok = token_queue.pop_front();
            s_tdata  <= tok.value;
            s_tuser  <= tok.cmd;
            s_tlast  <= tok.last;
            s_tvalid <= 1'b1;
            // every fourth stretch of 80 words runs back to back
            if ((sent_count / 80) % 4 == 1 || $urandom_range(99) < 55)
                send_gap = 0;
            else
                send_gap = rand_gap();
            sent_count++;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off that lets
    // the core fill up and stall its slave side
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        recv_cycles++;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 20) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            m_tready      <= 1'b0;
        end else if ((recv_cycles / 500) % 3 == 0 || $urandom_range(99) < 65) begin
            m_tready <= 1'b1;
        end else begin
            hold_left = rand_gap() - 1;
            m_tready <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: both handshakes sampled on the rising edge
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        rpn_result_t want;
        word_taken = aresetn && s_tvalid && s_tready;
        if (word_taken)
            rpn_eval_token(s_tuser, s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word: value=%h status=%0d",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: result_value mismatch: expected %h, got %h",
                             $time, want.value, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus, reset and end of run
    // ---------------------------------------------------------------
    initial begin
        int               k;
        int               len;
        int               depth;
        int               n;
        logic [CMD_W-1:0] cmd;
        bit               pause_marked;
        pause_marked = 1'b0;

        // Directed: every operator chained, wrap-around, not, large shift
        add_token(CMD_PUSH, '1, 1'b0);
        add_token(CMD_PUSH, 1, 1'b0);
        add_token(CMD_ADD, DATA_W'($urandom()), 1'b0);
        add_token(CMD_NOT, DATA_W'($urandom()), 1'b0);
        add_token(CMD_PUSH, 3, 1'b0);
        add_token(CMD_SUB, '0, 1'b0);
        add_token(CMD_PUSH, 7, 1'b0);
        add_token(CMD_MUL, '1, 1'b0);
        add_token(CMD_PUSH, 5, 1'b0);
        add_token(CMD_DIV, '0, 1'b0);
        add_token(CMD_PUSH, 3, 1'b0);
        add_token(CMD_MOD, '0, 1'b0);
        add_token(CMD_PUSH, 32'hA5A5_A5A5, 1'b0);
        add_token(CMD_XOR, '0, 1'b0);
        add_token(CMD_PUSH, 32'h0000_0F0F, 1'b0);
        add_token(CMD_OR, '0, 1'b0);
        add_token(CMD_PUSH, 32'h0000_FFFF, 1'b0);
        add_token(CMD_AND, '0, 1'b0);
        add_token(CMD_PUSH, 4, 1'b0);
        add_token(CMD_SHL, '0, 1'b0);
        add_token(CMD_PUSH, 35, 1'b0);
        add_token(CMD_SHR, '0, 1'b1);
        // empty stack at end, via an unused code
        add_token(CMD_W'((1 << CMD_W) - 1), '1, 1'b1);
        // missing operand
        add_token(CMD_ADD, '0, 1'b1);
        // modulo by zero
        add_token(CMD_PUSH, 5, 1'b0);
        add_token(CMD_PUSH, 0, 1'b0);
        add_token(CMD_MOD, '0, 1'b1);

        // Random expressions
        while (token_queue.size() < RANDOM_WORDS) begin
            if (!pause_marked && token_queue.size() >= RANDOM_WORDS / 2) begin
                pause_marked = 1'b1;
                mark_pause   = 1'b1;   // sender waits for a full drain here
            end
            case ($urandom_range(19))
                0, 1: begin
                    // push from one below full to two past it, then up to three operators
                    n = $urandom_range(DEPTH - 1, DEPTH + 2);
                    len = $urandom_range(3);
                    for (k = 0; k < n; k++)
                        add_token(CMD_PUSH, rand_operand(), (len == 0 && k == n - 1));
                    for (k = 0; k < len; k++)
                        add_token(pick_binary(), DATA_W'($urandom()), (k == len - 1));
                end
                2, 3, 4: begin
                    // noise: any code, errors and ignored tokens after them
                    len = $urandom_range(1, 8);
                    for (k = 0; k < len; k++)
                        add_token(CMD_W'($urandom_range((1 << CMD_W) - 1)), rand_operand(),
                                  (k == len - 1));
                end
                default: begin
                    // well-formed expression with random content
                    len   = $urandom_range(1, 24);
                    depth = 0;
                    for (k = 0; k < len; k++) begin
                        if (depth < 2 || (depth < DEPTH && $urandom_range(2) == 0)) begin
                            if (depth >= 1 && $urandom_range(5) == 0) begin
                                cmd = CMD_NOT;
                            end else begin
                                cmd = CMD_PUSH;
                                depth++;
                            end
                        end else begin
                            cmd = pick_binary();
                            depth--;
                        end
                        add_token(cmd, (cmd == CMD_PUSH) ? rand_operand()
                                                         : DATA_W'($urandom()),
                                  (k == len - 1));
                    end
                end
            endcase
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (token_queue.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
